/* hw/rtl/bqf_pkg.sv */
// ----------------------------------------------------------------------------
// bqf_pkg
// Shared types, constants and the micro-program of the two-section biquad.
// ----------------------------------------------------------------------------
package bqf_pkg;

  // default widths of the top-level parameters
  localparam int unsigned SAMPLE_WIDTH_DEF = 24;
  localparam int unsigned COEF_WIDTH_DEF   = 32;

  // fixed internal formats
  localparam int unsigned GUARD_BITS = 8;
  localparam int unsigned ACC_WIDTH  = 48;
  localparam int unsigned HALF_W     = ACC_WIDTH / 2;
  localparam int unsigned GAIN_WIDTH = 16;
  localparam int unsigned GAIN_FRAC  = 12;
  localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = GAIN_WIDTH'(4096);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_A0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B2    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TWO   = 3'd6;

  // micro-operation codes
  localparam int unsigned UOP_W = 4;
  localparam logic [UOP_W-1:0] UOP_NOP      = 4'd0;
  localparam logic [UOP_W-1:0] UOP_LOAD_IN  = 4'd1;
  localparam logic [UOP_W-1:0] UOP_LOAD_Z1  = 4'd2;
  localparam logic [UOP_W-1:0] UOP_MUL_LO   = 4'd3;
  localparam logic [UOP_W-1:0] UOP_MUL_HI   = 4'd4;
  localparam logic [UOP_W-1:0] UOP_MUL_ADD  = 4'd5;
  localparam logic [UOP_W-1:0] UOP_ACC_ADD  = 4'd6;
  localparam logic [UOP_W-1:0] UOP_ACC_SUB  = 4'd7;
  localparam logic [UOP_W-1:0] UOP_SAT_W    = 4'd8;
  localparam logic [UOP_W-1:0] UOP_STORE_Z1 = 4'd9;
  localparam logic [UOP_W-1:0] UOP_STORE_Z2 = 4'd10;
  localparam logic [UOP_W-1:0] UOP_OUT      = 4'd11;

  // multiplier coefficient selects
  localparam int unsigned CSEL_W = 3;
  localparam logic [CSEL_W-1:0] CSEL_A0   = 3'd0;
  localparam logic [CSEL_W-1:0] CSEL_A1   = 3'd1;
  localparam logic [CSEL_W-1:0] CSEL_A2   = 3'd2;
  localparam logic [CSEL_W-1:0] CSEL_B1   = 3'd3;
  localparam logic [CSEL_W-1:0] CSEL_B2   = 3'd4;
  localparam logic [CSEL_W-1:0] CSEL_GAIN = 3'd5;

  // program addresses the controller branches on
  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_SEC_END = 5'd23;
  localparam logic [STEP_W-1:0] STEP_OUT     = 5'd27;

  typedef struct packed {
    logic [UOP_W-1:0]  op;
    logic [CSEL_W-1:0] csel;
  } uop_t;

  // command from controller to datapath
  typedef struct packed {
    logic [UOP_W-1:0]  op;
    logic [CSEL_W-1:0] csel;
    logic              sec;
    logic              next_sec;
  } cmd_t;

  // micro-program: one section is steps 0..23, the output gain 24..27
  function automatic uop_t uop_at(input logic [STEP_W-1:0] step);
    uop_t u;
    u.op   = UOP_NOP;
    u.csel = CSEL_A0;
    case (step)
      5'd0: begin
        u.op = UOP_LOAD_Z1;
      end
      5'd1, 5'd6, 5'd10, 5'd15, 5'd19, 5'd24: begin
        u.op = UOP_MUL_LO;
      end
      5'd2, 5'd7, 5'd11, 5'd16, 5'd20, 5'd25: begin
        u.op = UOP_MUL_HI;
      end
      5'd3, 5'd8, 5'd12, 5'd17, 5'd21, 5'd26: begin
        u.op = UOP_MUL_ADD;
      end
      5'd4, 5'd9, 5'd18: begin
        u.op = UOP_ACC_ADD;
      end
      5'd13, 5'd22: begin
        u.op = UOP_ACC_SUB;
      end
      5'd5: begin
        u.op = UOP_SAT_W;
      end
      5'd14: begin
        u.op = UOP_STORE_Z1;
      end
      5'd23: begin
        u.op = UOP_STORE_Z2;
      end
      5'd27: begin
        u.op = UOP_OUT;
      end
      default: begin
        u.op = UOP_NOP;
      end
    endcase
    // coefficient of each product
    case (step)
      5'd1, 5'd2, 5'd3:     u.csel = CSEL_A0;
      5'd6, 5'd7, 5'd8:     u.csel = CSEL_A1;
      5'd10, 5'd11, 5'd12:  u.csel = CSEL_B1;
      5'd15, 5'd16, 5'd17:  u.csel = CSEL_A2;
      5'd19, 5'd20, 5'd21:  u.csel = CSEL_B2;
      5'd24, 5'd25, 5'd26:  u.csel = CSEL_GAIN;
      default:              u.csel = CSEL_A0;
    endcase
    return u;
  endfunction

endpackage

/* hw/rtl/bqf_ctrl.sv */
// ----------------------------------------------------------------------------
// bqf_ctrl
// Sequencer: steps the micro-program per word and owns the output handshake.
// ----------------------------------------------------------------------------
module bqf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  logic          two_stage_i,
  output bqf_pkg::cmd_t cmd_o
);
  import bqf_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic              state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              sec_q, sec_d;
  logic              out_valid_q, out_valid_d;
  uop_t              uop;

  assign uop = uop_at(step_q);

  // next state and command
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    sec_d        = sec_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    cmd_o.op       = UOP_NOP;
    cmd_o.csel     = uop.csel;
    cmd_o.sec      = sec_q;
    cmd_o.next_sec = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = UOP_LOAD_IN;
          step_d   = '0;
          sec_d    = 1'b0;
          state_d  = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.op = uop.op;
        if (step_q == STEP_OUT) begin
          // output register must be free or emptied this cycle
          if (!out_valid_q || out_ready_i) begin
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end else begin
            cmd_o.op = UOP_NOP;
          end
        end else if (step_q == STEP_SEC_END && two_stage_i && !sec_q) begin
          cmd_o.next_sec = 1'b1;
          sec_d          = 1'b1;
          step_d         = '0;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      sec_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      sec_q       <= sec_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/bqf_datapath.sv */
// ----------------------------------------------------------------------------
// bqf_datapath
// Configuration registers, delay registers, shared multiplier and accumulator.
// ----------------------------------------------------------------------------
module bqf_datapath #(
  parameter int unsigned SAMPLE_WIDTH = bqf_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned COEF_WIDTH   = bqf_pkg::COEF_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [bqf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [COEF_WIDTH-1:0]           cfg_data_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  sample_in_i,
  input  bqf_pkg::cmd_t                   cmd_i,
  output logic                            two_stage_o,
  output logic signed [SAMPLE_WIDTH-1:0]  sample_out_o
);
  import bqf_pkg::*;

  // multiplier coefficient port also carries the unsigned gain
  localparam int unsigned MCW  = (COEF_WIDTH > GAIN_WIDTH) ? COEF_WIDTH : GAIN_WIDTH + 1;
  localparam int unsigned MBW  = HALF_W + 1;
  localparam int unsigned MW   = MCW + MBW;
  localparam int unsigned PW   = MW + HALF_W;
  localparam int unsigned COEF_FRAC = COEF_WIDTH - 3;
  localparam int unsigned ACC_W     = PW - COEF_FRAC + 2;
  localparam int unsigned OUT_SHIFT = GAIN_FRAC + GUARD_BITS;
  localparam int unsigned X_PAD     = ACC_WIDTH - SAMPLE_WIDTH - GUARD_BITS;

  logic signed [COEF_WIDTH-1:0] coef_a0_q, coef_a1_q, coef_a2_q, coef_b1_q, coef_b2_q;
  logic [GAIN_WIDTH-1:0]        gain_q;
  logic                         two_stage_q;

  logic signed [ACC_WIDTH-1:0]  z1_q [2];
  logic signed [ACC_WIDTH-1:0]  z2_q [2];

  logic signed [ACC_WIDTH-1:0]    x_q, w_q;
  logic signed [MW-1:0]           mul_q;
  logic signed [PW-1:0]           prod_q;
  logic signed [ACC_W-1:0]        acc_q;
  logic signed [SAMPLE_WIDTH-1:0] out_q;

  logic signed [MCW-1:0]       mul_a;
  logic signed [MBW-1:0]       mul_b;
  logic signed [MW-1:0]        mul_full;
  logic signed [ACC_WIDTH-1:0] opnd;
  logic signed [PW-1:0]        prod_sh;
  logic signed [ACC_W-1:0]     prod_term;
  logic signed [ACC_W-1:0]     z1_ext, z2_ext;
  logic                        acc_ovf;
  logic signed [ACC_WIDTH-1:0] acc_sat;
  logic signed [PW-1:0]        out_sh;
  logic                        out_ovf;
  logic signed [SAMPLE_WIDTH-1:0] out_sat;

  // coefficient and operand select
  always_comb begin
    case (cmd_i.csel)
      CSEL_A0:   mul_a = MCW'(coef_a0_q);
      CSEL_A1:   mul_a = MCW'(coef_a1_q);
      CSEL_A2:   mul_a = MCW'(coef_a2_q);
      CSEL_B1:   mul_a = MCW'(coef_b1_q);
      CSEL_B2:   mul_a = MCW'(coef_b2_q);
      CSEL_GAIN: mul_a = signed'(MCW'(gain_q));
      default:   mul_a = '0;
    endcase
    if (cmd_i.csel == CSEL_A0 || cmd_i.csel == CSEL_A1 || cmd_i.csel == CSEL_A2) begin
      opnd = x_q;
    end else begin
      opnd = w_q;
    end
  end

  // low half unsigned, high half signed
  assign mul_b = (cmd_i.op == UOP_MUL_LO)
               ? signed'({1'b0, opnd[HALF_W-1:0]})
               : signed'({opnd[ACC_WIDTH-1], opnd[ACC_WIDTH-1:HALF_W]});
  assign mul_full = mul_a * mul_b;

  // product scaled back by the coefficient fraction, floor by arithmetic shift
  assign prod_sh   = prod_q >>> COEF_FRAC;
  assign prod_term = prod_sh[ACC_W-1:0];
  assign z1_ext    = ACC_W'(z1_q[cmd_i.sec]);
  assign z2_ext    = ACC_W'(z2_q[cmd_i.sec]);

  // accumulator saturation to the delay register width
  assign acc_ovf = !((&acc_q[ACC_W-1:ACC_WIDTH-1]) || !(|acc_q[ACC_W-1:ACC_WIDTH-1]));
  assign acc_sat = !acc_ovf ? acc_q[ACC_WIDTH-1:0]
                 : acc_q[ACC_W-1] ? signed'({1'b1, {(ACC_WIDTH-1){1'b0}}})
                                  : signed'({1'b0, {(ACC_WIDTH-1){1'b1}}});

  // gained output, floor then saturate to the sample width
  assign out_sh  = prod_q >>> OUT_SHIFT;
  assign out_ovf = !((&out_sh[PW-1:SAMPLE_WIDTH-1]) || !(|out_sh[PW-1:SAMPLE_WIDTH-1]));
  assign out_sat = !out_ovf ? out_sh[SAMPLE_WIDTH-1:0]
                 : out_sh[PW-1] ? signed'({1'b1, {(SAMPLE_WIDTH-1){1'b0}}})
                                : signed'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a0_q   <= '0;
      coef_a1_q   <= '0;
      coef_a2_q   <= '0;
      coef_b1_q   <= '0;
      coef_b2_q   <= '0;
      gain_q      <= GAIN_RESET;
      two_stage_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_A0:   coef_a0_q   <= cfg_data_i;
        REG_A1:   coef_a1_q   <= cfg_data_i;
        REG_A2:   coef_a2_q   <= cfg_data_i;
        REG_B1:   coef_b1_q   <= cfg_data_i;
        REG_B2:   coef_b2_q   <= cfg_data_i;
        REG_GAIN: gain_q      <= cfg_data_i[GAIN_WIDTH-1:0];
        REG_TWO:  two_stage_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // delay registers of both sections
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z1_q[0] <= '0;
      z1_q[1] <= '0;
      z2_q[0] <= '0;
      z2_q[1] <= '0;
    end else begin
      if (cmd_i.op == UOP_STORE_Z1) begin
        z1_q[cmd_i.sec] <= acc_sat;
      end
      if (cmd_i.op == UOP_STORE_Z2) begin
        z2_q[cmd_i.sec] <= acc_sat;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      UOP_LOAD_IN: begin
        x_q <= {{X_PAD{sample_in_i[SAMPLE_WIDTH-1]}}, sample_in_i, {GUARD_BITS{1'b0}}};
      end
      UOP_LOAD_Z1: begin
        acc_q <= z1_ext;
      end
      UOP_MUL_LO: begin
        mul_q <= mul_full;
      end
      UOP_MUL_HI: begin
        mul_q  <= mul_full;
        prod_q <= PW'(mul_q);
      end
      UOP_MUL_ADD: begin
        prod_q <= prod_q + {mul_q, {HALF_W{1'b0}}};
      end
      UOP_ACC_ADD: begin
        acc_q <= acc_q + prod_term;
      end
      UOP_ACC_SUB: begin
        acc_q <= acc_q - prod_term;
      end
      UOP_SAT_W: begin
        w_q   <= acc_sat;
        acc_q <= z2_ext;
      end
      UOP_STORE_Z1: begin
        acc_q <= '0;
      end
      UOP_OUT: begin
        out_q <= out_sat;
      end
      default: begin
      end
    endcase
    // section output feeds the second section
    if (cmd_i.next_sec) begin
      x_q <= w_q;
    end
  end

  assign two_stage_o  = two_stage_q;
  assign sample_out_o = out_q;

endmodule

/* hw/rtl/biquad_filter_two_stage_unit.sv */
// ----------------------------------------------------------------------------
// biquad_filter_two_stage_unit
// Transposed direct form II biquad, optional second section, output gain.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  input     in_valid_i / in_ready_o / sample_in_i     word in
//  output    out_valid_o / out_ready_i / sample_out_o  word out
//  config    cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i  register write
//
//  the shared multiplier (coefficient by half of a 48-bit operand) forms each
//  product in steps: low half, high half, combine, then accumulate
//  reset clears coefficients, gain to unity, and all four delay registers
//  a stalled output word holds in its register; the next input word is taken
//  and runs until it needs that register
// ----------------------------------------------------------------------------
module biquad_filter_two_stage_unit #(
  parameter int unsigned SAMPLE_WIDTH = bqf_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned COEF_WIDTH   = bqf_pkg::COEF_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bqf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [COEF_WIDTH-1:0]          cfg_data_i
);
  import bqf_pkg::*;

  cmd_t cmd;
  logic two_stage;

  // sequencer
  bqf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .two_stage_i (two_stage),
    .cmd_o       (cmd)
  );

  // arithmetic and storage
  bqf_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .sample_in_i  (sample_in_i),
    .cmd_i        (cmd),
    .two_stage_o  (two_stage),
    .sample_out_o (sample_out_o)
  );

  // register writes always land at once
  assign cfg_ready_o = 1'b1;

endmodule

/* hw/rtl/bqf_checker.sv */
// ----------------------------------------------------------------------------
// bqf_checker
// Port-level checks of word flow, bound to the top level.
// ----------------------------------------------------------------------------
module bqf_checker #(
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [SAMPLE_WIDTH-1:0] sample_out_o
);

  logic [1:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = out_valid_o & out_ready_i;

  // words taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 2'd1;
    end
  end

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_out_o))
    else $error("output word changed while stalled");

  // no output without a word in flight
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 2'd0)
    else $error("output word with nothing accepted");

  // at most one word computing and one waiting
  a_pending_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("too many words in flight");

  // block is busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("input ready right after accept");

endmodule

bind biquad_filter_two_stage_unit bqf_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_bqf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .sample_out_o (sample_out_o)
);

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-section biquad with output gain.
// Samples go in over a valid/ready channel and are predicted bit-exactly at
// acceptance by a fixed-point filter held here. Each filtered word is compared
// in order. Coefficients, gain and cascade are reprogrammed between batches,
// and both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bqf_pkg::*;

  localparam int unsigned SW        = SAMPLE_WIDTH_DEF;
  localparam int unsigned CW        = COEF_WIDTH_DEF;
  localparam int unsigned COEF_FRAC = CW - 3;
  localparam int unsigned RUN_LIMIT = 400000;
  localparam int unsigned LONG_HOLD = 700;
  localparam int unsigned HOLD_AT_A = 60;
  localparam int unsigned HOLD_AT_B = 400;
  localparam int unsigned DRAIN_CYC = 60;
  localparam int unsigned MAX_SHOWN = 10;

  // register index past the end of the map, writes are dropped
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  localparam logic signed [SW-1:0] SMAX = 24'h7FFFFF;
  localparam logic signed [SW-1:0] SMIN = 24'h800000;
  localparam logic [CW-1:0] Q29_ONE  = 32'h2000_0000;
  localparam logic [CW-1:0] COEF_MAX = 32'h7FFF_FFFF;
  localparam logic [CW-1:0] COEF_MIN = 32'h8000_0000;

  typedef logic signed [95:0] wide_t;

  localparam wide_t ACC_HI = (wide_t'(1) <<< (ACC_WIDTH - 1)) - wide_t'(1);
  localparam wide_t ACC_LO = -ACC_HI - wide_t'(1);
  localparam wide_t OUT_HI = wide_t'(SMAX);
  localparam wide_t OUT_LO = wide_t'(SMIN);

  typedef enum int unsigned {IDLE_RANDOM, IDLE_NONE, IDLE_SPARSE} idle_mode_e;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic          in_valid  = 1'b0;
  logic          in_ready_o;
  logic [SW-1:0] sample_in = '0;
  logic          out_valid_o;
  logic          out_ready = 1'b0;
  logic [SW-1:0] sample_out_o;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0]        cfg_data  = '0;

  // filter settings as the block should hold them
  logic signed [CW-1:0] ff0 = '0, ff1 = '0, ff2 = '0, fb1 = '0, fb2 = '0;
  logic [GAIN_WIDTH-1:0] gain_q12 = GAIN_RESET;
  logic cascade = 1'b0;
  // delay taps, [section][tap]
  wide_t delay_line [2][2];

  logic [SW-1:0] sample_q [$];
  logic [SW-1:0] filtered_q [$];

  idle_mode_e gap_mode   = IDLE_RANDOM;
  idle_mode_e stall_mode = IDLE_RANDOM;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned n_out      = 0;
  int unsigned n_bad      = 0;
  int unsigned n_cycles   = 0;

  biquad_filter_two_stage_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .sample_out_o (sample_out_o),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // fixed-point filter
  // ---------------------------------------------------------------------------

  function automatic wide_t clip(input wide_t v, input wide_t hi, input wide_t lo);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // coefficient times value, floored back to the value's scale
  function automatic wide_t coef_mul(input logic signed [CW-1:0] c, input wide_t v);
    wide_t p;
    p = wide_t'(c) * v;
    return p >>> COEF_FRAC;
  endfunction

  // one transposed direct form II section, updates its delay taps
  function automatic wide_t biquad_section(input wide_t x, input int unsigned sec);
    wide_t w, n1;
    w  = clip(coef_mul(ff0, x) + delay_line[sec][0], ACC_HI, ACC_LO);
    n1 = coef_mul(ff1, x) - coef_mul(fb1, w) + delay_line[sec][1];
    delay_line[sec][1] = clip(coef_mul(ff2, x) - coef_mul(fb2, w), ACC_HI, ACC_LO);
    delay_line[sec][0] = clip(n1, ACC_HI, ACC_LO);
    return w;
  endfunction

  function automatic logic [SW-1:0] filter_sample(input logic signed [SW-1:0] s);
    wide_t x, y, r;
    x = wide_t'(s) <<< GUARD_BITS;
    y = biquad_section(x, 0);
    if (cascade) y = biquad_section(y, 1);
    r = (y * wide_t'(gain_q12)) >>> (GAIN_FRAC + GUARD_BITS);
    r = clip(r, OUT_HI, OUT_LO);
    return r[SW-1:0];
  endfunction

  function automatic int unsigned draw_wait(input idle_mode_e mode);
    case (mode)
      IDLE_RANDOM: return $urandom_range(0, 15);
      IDLE_NONE:   return 0;
      default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // input driver, predicts each word as it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready_o) begin
        filtered_q.push_back(filter_sample(sample_in));
        gap_left = draw_wait(gap_mode);
      end
      // hold an offered word until it is taken
      if (!(in_valid && !in_ready_o)) begin
        if (gap_left > 0) begin
          if (in_ready_o) gap_left--;
          in_valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          in_valid  <= 1'b1;
          sample_in <= sample_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output monitor, stall counted while a word is waiting
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    logic [SW-1:0] want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready) begin
        n_out++;
        if (filtered_q.size() == 0) begin
          n_bad++;
          if (n_bad <= MAX_SHOWN)
            $display("word %0d: got %0d with nothing expected", n_out,
                     $signed(sample_out_o));
        end else begin
          want = filtered_q.pop_front();
          if (sample_out_o !== want) begin
            n_bad++;
            if (n_bad <= MAX_SHOWN)
              $display("word %0d: sample_out expected %0d, got %0d", n_out,
                       $signed(want), $signed(sample_out_o));
          end
        end
        // long back-pressure so the block fills up and blocks its input
        if (n_out == HOLD_AT_A || n_out == HOLD_AT_B) stall_left = LONG_HOLD;
        else stall_left = draw_wait(stall_mode);
      end
      if (stall_left > 0) begin
        if (out_valid_o) stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles == RUN_LIMIT) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      REG_A0:   ff0 = data;
      REG_A1:   ff1 = data;
      REG_A2:   ff2 = data;
      REG_B1:   fb1 = data;
      REG_B2:   fb2 = data;
      REG_GAIN: gain_q12 = data[GAIN_WIDTH-1:0];
      REG_TWO:  cascade = data[0];
      default: ;
    endcase
  endtask

  // gain and cascade land with junk in the unused upper bits
  task automatic write_gain(input logic [GAIN_WIDTH-1:0] g);
    logic [CW-1:0] d;
    d = $urandom;
    d[GAIN_WIDTH-1:0] = g;
    write_reg(REG_GAIN, d);
  endtask

  task automatic write_cascade(input logic on);
    logic [CW-1:0] d;
    d = $urandom;
    d[0] = on;
    write_reg(REG_TWO, d);
  endtask

  // stable pole pair from radius and angle, or raw random words
  task automatic load_filter(input bit wild);
    logic [CW-1:0] c [5];
    real r, th;
    if (wild) begin
      foreach (c[i]) c[i] = $urandom;
    end else begin
      r  = $urandom_range(300, 990) / 1000.0;
      th = $urandom_range(50, 3100) / 1000.0;
      for (int i = 0; i < 3; i++)
        c[i] = $rtoi(($urandom_range(0, 2000) / 1000.0 - 1.0) * 536870912.0);
      c[3] = $rtoi(-2.0 * r * $cos(th) * 536870912.0);
      c[4] = $rtoi(r * r * 536870912.0);
    end
    write_reg(REG_A0, c[0]);
    write_reg(REG_A1, c[1]);
    write_reg(REG_A2, c[2]);
    write_reg(REG_B1, c[3]);
    write_reg(REG_B2, c[4]);
  endtask

  function automatic logic [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? SMAX : SMIN;
      1, 2:    return SW'($signed($urandom_range(0, 2000)) - 1000);
      default: return SW'($urandom);
    endcase
  endfunction

  task automatic push_random(input int unsigned n);
    repeat (n) sample_q.push_back(pick_sample());
  endtask

  // every offered word taken and every filtered word back, sampled mid-cycle
  task automatic wait_drained();
    do @(negedge clk_i);
    while (sample_q.size() != 0 || filtered_q.size() != 0 || in_valid);
  endtask

  initial begin
    logic [GAIN_WIDTH-1:0] g;
    foreach (delay_line[s, t]) delay_line[s][t] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // coefficients still zero after reset, output stays at zero
    sample_q.push_back('0);
    sample_q.push_back(SMAX);
    sample_q.push_back(SMIN);
    sample_q.push_back('1);
    sample_q.push_back(SW'(1));
    wait_drained();

    // pass-through with maximum gain, out-of-map index ignored
    write_reg(REG_A0, Q29_ONE);
    write_reg(REG_A1, '0);
    write_reg(REG_A2, '0);
    write_reg(REG_B1, '0);
    write_reg(REG_B2, '0);
    write_gain('1);
    write_cascade(1'b0);
    write_reg(REG_NONE, $urandom);
    sample_q.push_back(SMAX);
    sample_q.push_back(SMIN);
    sample_q.push_back(SW'(1));
    sample_q.push_back('1);
    sample_q.push_back(24'h555555);
    wait_drained();

    // extreme coefficients, drives the delay taps into saturation
    write_reg(REG_A0, COEF_MIN);
    write_reg(REG_A1, COEF_MAX);
    write_reg(REG_A2, COEF_MIN);
    write_reg(REG_B1, COEF_MAX);
    write_reg(REG_B2, COEF_MIN);
    write_gain(GAIN_RESET);
    write_cascade(1'b1);
    repeat (4) begin
      sample_q.push_back(SMAX);
      sample_q.push_back(SMIN);
    end
    wait_drained();

    // drop the second section with zero gain, then bring it back
    write_cascade(1'b0);
    write_gain('0);
    push_random(3);
    wait_drained();
    write_cascade(1'b1);
    write_gain('1);
    push_random(3);
    wait_drained();

    // random batches, each with fresh settings and idle behavior
    for (int p = 0; p < 5; p++) begin
      gap_mode   = idle_mode_e'(p % 3);
      stall_mode = idle_mode_e'(p % 3);
      load_filter(p == 1 || p == 4);
      case (p)
        1:       g = '1;
        2:       g = GAIN_RESET;
        default: g = $urandom;
      endcase
      write_gain(g);
      write_cascade($urandom_range(0, 1));
      push_random(110);
      wait_drained();
    end

    repeat (DRAIN_CYC) @(posedge clk_i);
    if (n_bad == 0 && filtered_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d words still expected", n_bad, filtered_q.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/bqf_pkg.sv
hw/rtl/bqf_ctrl.sv
hw/rtl/bqf_datapath.sv
hw/rtl/biquad_filter_two_stage_unit.sv
hw/rtl/bqf_checker.sv
test/tb_top.sv
